@@ sv/fifo_queue_with_search_defines.svh @@
// Assertion macros for the queue RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define FQS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/fqs_pkg.sv @@
`default_nettype none

package fqs_pkg;

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // Decoded command, one flag per operation.
    typedef struct packed {
        logic enq;
        logic deq;
        logic srch;
        logic clr;
    } t_cls;

endpackage

`default_nettype wire

@@ sv/fqs_ram.sv @@
`default_nettype none

module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/fqs_front.sv @@
`default_nettype none

module fqs_front
    import fqs_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [1:0]            i_command,
    input  wire logic [DATA_WIDTH-1:0] i_value,
    output logic                       o_op_valid,
    input  wire logic                  i_op_ready,
    output t_cls                       o_cls,
    output logic [DATA_WIDTH-1:0]      o_val
);

    // Two-slot queue of decoded requests.
    t_cls                  r_q_cls [2];
    logic [DATA_WIDTH-1:0] r_q_val [2];
    logic                  r_wr;
    logic                  r_rd;
    logic [1:0]            r_cnt;

    t_cls n_cls;
    logic push;
    logic pop;

    always_comb begin
        n_cls = '0;
        case (i_command)
            CMD_ENQ:    n_cls.enq  = 1'b1;
            CMD_DEQ:    n_cls.deq  = 1'b1;
            CMD_SEARCH: n_cls.srch = 1'b1;
            default:    n_cls.clr  = 1'b1;
        endcase
    end

    assign o_ready    = (r_cnt != 2'd2);
    assign o_op_valid = (r_cnt != 2'd0);
    assign o_cls      = r_q_cls[r_rd];
    assign o_val      = r_q_val[r_rd];
    assign push       = i_valid && o_ready;
    assign pop        = o_op_valid && i_op_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q_cls[r_wr] <= n_cls;
                r_q_val[r_wr] <= i_value;
                r_wr          <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/fqs_back.sv @@
`default_nettype none
`include "fifo_queue_with_search_defines.svh"

module fqs_back
    import fqs_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_op_valid,
    output logic                       o_op_ready,
    input  wire t_cls                  i_cls,
    input  wire logic [DATA_WIDTH-1:0] i_val,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [DATA_WIDTH-1:0]      o_data,
    output logic                       o_found,
    output logic [1:0]                 o_status,
    output logic                       o_empty
);

    localparam int AW    = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SRCH
    } t_state;

    t_state                r_state;
    logic [AW-1:0]         r_head;
    logic [AW-1:0]         r_tail;
    logic [AW-1:0]         r_idx;
    logic [OCC_W-1:0]      r_occ;
    logic [OCC_W-1:0]      r_left;
    logic [DATA_WIDTH-1:0] r_val;
    logic                  r_ovalid;
    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_found;
    t_status               r_status;
    logic                  r_empty;

    logic                  op_take;
    logic                  out_take;
    logic                  res_set;
    logic                  full;
    logic                  is_empty;
    logic                  ram_we;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    function automatic logic [AW-1:0] f_adv(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    assign full       = (r_occ == OCC_W'(DEPTH));
    assign is_empty   = (r_occ == '0);
    assign out_take   = r_ovalid && i_ready;
    assign o_op_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign op_take    = i_op_valid && o_op_ready;
    assign ram_we     = op_take && i_cls.enq && !full;
    assign ram_raddr  = (r_state == S_IDLE) ? r_head : r_idx;

    // A result is loaded whenever a request finishes: at once for enqueue, clear
    // and anything on an empty queue, otherwise when the dequeue or search ends.
    always_comb begin
        res_set = 1'b0;
        case (r_state)
            S_IDLE: begin
                res_set = op_take && !(i_cls.deq && !is_empty) && !(i_cls.srch && !is_empty);
            end
            S_DEQ: begin
                res_set = 1'b1;
            end
            S_SRCH: begin
                res_set = (ram_rdata == r_val) || (r_left == OCC_W'(1));
            end
            default: begin
                res_set = 1'b0;
            end
        endcase
    end

    fqs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (i_val),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (res_set) begin
                r_ovalid <= 1'b1;
            end else if (out_take) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (op_take) begin
                        r_val   <= i_val;
                        r_data  <= '0;
                        r_found <= 1'b0;
                        if (i_cls.enq) begin
                            if (full) begin
                                r_status <= ST_OVERFLOW;
                                r_empty  <= 1'b0;
                            end else begin
                                r_status <= ST_OK;
                                r_empty  <= 1'b0;
                                r_tail   <= f_adv(r_tail);
                                r_occ    <= r_occ + 1'b1;
                            end
                        end else if (i_cls.deq) begin
                            if (is_empty) begin
                                r_status <= ST_UNDERFLOW;
                                r_empty  <= 1'b1;
                            end else begin
                                r_state <= S_DEQ;
                            end
                        end else if (i_cls.srch) begin
                            if (is_empty) begin
                                r_status <= ST_OK;
                                r_empty  <= 1'b1;
                            end else begin
                                r_idx   <= f_adv(r_head);
                                r_left  <= r_occ;
                                r_state <= S_SRCH;
                            end
                        end else begin
                            r_head   <= '0;
                            r_tail   <= '0;
                            r_occ    <= '0;
                            r_status <= ST_OK;
                            r_empty  <= 1'b1;
                        end
                    end
                end
                S_DEQ: begin
                    r_data   <= ram_rdata;
                    r_status <= ST_OK;
                    r_empty  <= (r_occ == OCC_W'(1));
                    r_head   <= f_adv(r_head);
                    r_occ    <= r_occ - 1'b1;
                    r_state  <= S_IDLE;
                end
                S_SRCH: begin
                    r_idx <= f_adv(r_idx);
                    if (ram_rdata == r_val) begin
                        r_found  <= 1'b1;
                        r_status <= ST_OK;
                        r_empty  <= 1'b0;
                        r_state  <= S_IDLE;
                    end else if (r_left == OCC_W'(1)) begin
                        r_status <= ST_OK;
                        r_empty  <= 1'b0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_left <= r_left - 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_data   = r_data;
    assign o_found  = r_found;
    assign o_status = r_status;
    assign o_empty  = r_empty;

    `FQS_ASSERT(a_occ_bound, r_occ <= OCC_W'(DEPTH), "occupancy exceeds depth")
    `FQS_ASSERT(a_ptr_meet, !(is_empty || full) || (r_head == r_tail), "bad pointers")
    `FQS_ASSERT(a_busy_no_result, (r_state == S_IDLE) || !r_ovalid, "result pending while busy")
    `FQS_ASSERT_NEXT(a_enq_count, ram_we, r_occ == $past(r_occ) + 1'b1, "enqueue lost")

endmodule

`default_nettype wire

@@ sv/fifo_queue_with_search.sv @@
// First-in first-out queue of signed words with a search command.
// Requests arrive on i_valid/o_ready with i_command (0 enqueue, 1 dequeue,
// 2 search, 3 clear) and i_value. Every request yields exactly one result on
// o_valid/i_ready: o_data_out, o_found, o_status (0 ok, 1 underflow, 2 overflow)
// and o_empty_res, delivered in request order.
// A request is accepted into a two-deep request queue and is registered there
// until the executing back end takes it. An enqueue or clear result is loaded
// as the back end takes the request, a dequeue result once the storage RAM has
// been read, and a search result once the search, reading one stored entry per
// cycle from the storage RAM, matches or runs out of entries.
// The back end takes one enqueue or clear per cycle while the receiver keeps
// up; it takes no new request while a dequeue or search is under way, since each
// waits on the registered read port of the storage RAM.
// A stalled receiver holds its result in the output register; the request queue
// keeps taking requests until both of its slots are full, then drops o_ready.
// Synchronous reset empties the queue and both request paths. Stored words are
// not cleared, since no entry is read before it is written.
`default_nettype none

module fifo_queue_with_search
    import fqs_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [1:0]                   i_command,
    input  wire logic signed [DATA_WIDTH-1:0] i_value,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0]      o_data_out,
    output logic                              o_found,
    output logic [1:0]                        o_status,
    output logic                              o_empty_res
);

    // Decoded requests travel from the front end to the back end here.
    logic                  op_valid;
    logic                  op_ready;
    t_cls                  op_cls;
    logic [DATA_WIDTH-1:0] op_val;
    logic [DATA_WIDTH-1:0] res_data;

    // The front end decodes each command and buffers it in two slots, so the
    // requester is held up by a long search in the back end only once both are full.
    fqs_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_value    (i_value),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready),
        .o_cls      (op_cls),
        .o_val      (op_val)
    );

    // The back end owns the ring pointers, the count and the storage RAM, and
    // registers each result until the receiver takes it.
    fqs_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .o_op_ready (op_ready),
        .i_cls      (op_cls),
        .i_val      (op_val),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (res_data),
        .o_found    (o_found),
        .o_status   (o_status),
        .o_empty    (o_empty_res)
    );

    assign o_data_out = res_data;

endmodule

`default_nettype wire

@@ verif/fifo_queue_with_search_tb.sv @@
`default_nettype none

// Checks the searchable queue end to end through its request and result
// channels. Every accepted request is run through a behavioral copy of the
// ring store, and the predicted result is queued. Each result the block
// delivers is compared field by field with the oldest prediction.
module fifo_queue_with_search_tb;
    import fqs_pkg::*;

    localparam int QDEPTH     = 16;
    localparam int QWIDTH     = 32;
    localparam int PTR_W      = $clog2(QDEPTH);
    localparam int CYCLE_CAP  = 1000000;
    // A search can walk the whole store, so allow that plus the pipeline.
    localparam int SETTLE_CYC = QDEPTH + 8;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] word;
        bit          drain_first;  // hold this request until all results are back
    } t_request;

    typedef struct {
        logic signed [QWIDTH-1:0] data;
        logic                     found;
        t_status                  status;
        logic                     empty;
    } t_queue_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic [1:0]               in_command = CMD_ENQ;
    logic signed [QWIDTH-1:0] in_value = '0;
    logic                     out_ready = 1'b0;
    wire                      dut_ready;
    wire                      dut_valid;
    wire signed [QWIDTH-1:0]  dut_data;
    wire                      dut_found;
    wire [1:0]                dut_status;
    wire                      dut_empty;

    fifo_queue_with_search #(
        .DEPTH      (QDEPTH),
        .DATA_WIDTH (QWIDTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .o_ready     (dut_ready),
        .i_command   (in_command),
        .i_value     (in_value),
        .o_valid     (dut_valid),
        .i_ready     (out_ready),
        .o_data_out  (dut_data),
        .o_found     (dut_found),
        .o_status    (dut_status),
        .o_empty_res (dut_empty)
    );

    t_request      request_backlog[$];
    t_queue_result awaited_results[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    logic [31:0]   word_pool[8];

    // Shadow copy of the queue state.
    logic [QWIDTH-1:0] shadow_words[QDEPTH];
    logic [PTR_W-1:0]  shadow_head = '0;
    logic [PTR_W-1:0]  shadow_tail = '0;
    int                shadow_count = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Applies one request to the shadow queue and returns the result the
    // block must produce for it.
    function automatic t_queue_result predict_queue_result(t_cmd cmd, logic [31:0] word);
        t_queue_result    r;
        logic [PTR_W-1:0] idx;
        r.data   = '0;
        r.found  = 1'b0;
        r.status = ST_OK;
        case (cmd)
            CMD_ENQ: begin
                if (shadow_count == QDEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    shadow_words[shadow_tail] = word;
                    shadow_tail  = shadow_tail + 1'b1;
                    shadow_count = shadow_count + 1;
                end
            end
            CMD_DEQ: begin
                if (shadow_count == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.data       = shadow_words[shadow_head];
                    shadow_head  = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1;
                end
            end
            CMD_SEARCH: begin
                idx = shadow_head;
                for (int n = 0; n < shadow_count; n++) begin
                    if (shadow_words[idx] == word) r.found = 1'b1;
                    idx = idx + 1'b1;
                end
            end
            default: begin
                shadow_head  = '0;
                shadow_tail  = '0;
                shadow_count = 0;
            end
        endcase
        r.empty = (shadow_count == 0);
        return r;
    endfunction

    // Mostly back to back, sometimes a short gap, now and then a long one.
    function automatic int draw_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Half the words come from a small pool so that searches hit often.
    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return word_pool[$urandom_range(0, 7)];
        if (r == 5) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    task automatic push_request(t_cmd cmd, logic [31:0] word, bit drain_first);
        t_request q;
        q.cmd         = cmd;
        q.word        = word;
        q.drain_first = drain_first;
        request_backlog.push_back(q);
    endtask

    // Driver: presents requests from the backlog and predicts each one as it
    // is accepted.
    t_request tx_current;
    int       tx_gap = 0;
    int       tx_sent = 0;
    bit       tx_quiet = 1'b0;

    always @(posedge i_clk) begin
        logic busy;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            busy = in_valid;
            if (in_valid && dut_ready) begin
                awaited_results.push_back(
                    predict_queue_result(tx_current.cmd, tx_current.word));
                busy    = 1'b0;
                tx_sent = tx_sent + 1;
                if (tx_sent % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
                tx_gap  = draw_gap(tx_quiet);
            end
            if (!busy) begin
                if (tx_gap > 0) begin
                    tx_gap = tx_gap - 1;
                end else if (request_backlog.size() != 0 &&
                             !(request_backlog[0].drain_first &&
                               awaited_results.size() != 0)) begin
                    tx_current = request_backlog.pop_front();
                    in_command <= tx_current.cmd;
                    in_value   <= tx_current.word;
                    busy = 1'b1;
                end
            end
            in_valid <= busy;
        end
    end

    // Monitor: takes results, checks them, and stalls the result channel.
    t_queue_result rx_expected;
    int            rx_hold = 0;
    int            rx_seen = 0;
    bit            rx_quiet = 1'b0;

    always @(posedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (dut_valid && out_ready) begin
                if (awaited_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display({"ERROR: result with none pending: ",
                                  "data=%0d found=%0d status=%0d empty=%0d"},
                                 dut_data, dut_found, dut_status, dut_empty);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    rx_expected = awaited_results.pop_front();
                    if (dut_data !== rx_expected.data || dut_found !== rx_expected.found ||
                        dut_status !== rx_expected.status ||
                        dut_empty !== rx_expected.empty) begin
                        if (mismatch_count < 10)
                            $display({"ERROR: result %0d: expected data=%0d found=%0d ",
                                      "status=%0d empty=%0d, got data=%0d found=%0d ",
                                      "status=%0d empty=%0d"},
                                     rx_seen, rx_expected.data, rx_expected.found,
                                     rx_expected.status, rx_expected.empty,
                                     dut_data, dut_found, dut_status, dut_empty);
                        mismatch_count = mismatch_count + 1;
                    end
                end
                rx_seen = rx_seen + 1;
                if (rx_seen % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
                rx_hold = draw_gap(rx_quiet);
            end
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("fifo_queue_with_search verification failed");
            $finish;
        end
    end

    initial begin
        t_cmd cmd;
        int   made;
        int   burst_len;
        int   mode;
        int   r;
        bit   first_in_burst;

        for (int k = 0; k < 8; k++) word_pool[k] = $urandom();

        // Directed part: empty-queue corner cases, extreme words, a full store
        // with an overflow, a search over all entries, then clear and underflow.
        push_request(CMD_DEQ, 32'hdead_beef, 1'b0);
        push_request(CMD_SEARCH, 32'h0000_0000, 1'b0);
        push_request(CMD_CLEAR, 32'hffff_ffff, 1'b0);
        push_request(CMD_ENQ, 32'h8000_0000, 1'b0);
        push_request(CMD_ENQ, 32'h7fff_ffff, 1'b0);
        push_request(CMD_ENQ, 32'h0000_0000, 1'b0);
        push_request(CMD_ENQ, 32'hffff_ffff, 1'b0);
        for (int k = 0; k < QDEPTH - 4; k++) push_request(CMD_ENQ, word_pool[k % 8] ^ k, 1'b0);
        push_request(CMD_ENQ, 32'h1234_5678, 1'b0);
        push_request(CMD_SEARCH, word_pool[(QDEPTH - 5) % 8] ^ (QDEPTH - 5), 1'b0);
        push_request(CMD_SEARCH, 32'h1234_5678, 1'b0);
        push_request(CMD_DEQ, 32'h0000_0000, 1'b0);
        push_request(CMD_CLEAR, 32'h0000_0000, 1'b0);
        push_request(CMD_DEQ, 32'h0000_0000, 1'b0);

        // Random part in bursts: fill runs drive the store to full, drain runs
        // empty it, mixed runs stir everything. Some bursts wait for all
        // outstanding results before starting.
        made = 0;
        while (made < 1625) begin
            mode           = $urandom_range(0, 2);
            burst_len      = $urandom_range(10, 30);
            first_in_burst = (made == 0) || ($urandom_range(0, 14) == 0);
            for (int k = 0; k < burst_len; k++) begin
                r = $urandom_range(0, 99);
                case (mode)
                    0: cmd = (r < 80) ? CMD_ENQ : (r < 95) ? CMD_SEARCH : CMD_DEQ;
                    1: cmd = (r < 75) ? CMD_DEQ : (r < 95) ? CMD_SEARCH : CMD_ENQ;
                    default: cmd = (r < 40) ? CMD_ENQ : (r < 75) ? CMD_DEQ :
                                   (r < 97) ? CMD_SEARCH : CMD_CLEAR;
                endcase
                push_request(cmd, pick_word(), first_in_burst && (k == 0));
                made = made + 1;
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_backlog.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("fifo_queue_with_search verification clean");
        end else begin
            $display("fifo_queue_with_search verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ fifo_queue_with_search.f @@
+incdir+sv
sv/fqs_pkg.sv
sv/fqs_ram.sv
sv/fqs_front.sv
sv/fqs_back.sv
sv/fifo_queue_with_search.sv
verif/fifo_queue_with_search_tb.sv
